// File: design/assert_macros.svh
// Assertion macros used by triangle_box_overlap_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg
// Types and constants for the triangle versus box overlap pipeline.
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int CoordBits = 24;
  localparam int HalfBits  = 23;
  localparam int NumStages = 8;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0]   rel_t;     // vertex minus center
  typedef logic signed [CoordBits+1:0] edge_t;    // difference of two rel_t
  typedef logic        [HalfBits-1:0]  half_t;
  typedef logic signed [50:0]          prod_t;    // edge times rel
  typedef logic signed [51:0]          proj_t;    // difference of two prod_t
  typedef logic        [48:0]          radp_t;    // edge magnitude times half size
  typedef logic        [49:0]          rad_t;
  typedef logic signed [51:0]          nprod_t;   // edge times edge
  typedef logic signed [52:0]          norm_t;
  typedef logic signed [52:0]          plo_t;     // low normal part times rel
  typedef logic signed [50:0]          phi_t;     // high normal part times rel
  typedef logic        [49:0]          rlo_t;     // low magnitude part times half
  typedef logic        [48:0]          rhi_t;     // high magnitude part times half
  typedef logic signed [79:0]          wide_t;

  typedef enum logic [1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  // Cyclic axis successors.
  localparam int Next1 [3] = '{1, 2, 0};
  localparam int Next2 [3] = '{2, 0, 1};

  localparam half_t HalfReset = half_t'(2048);

endpackage

// File: design/triangle_box_overlap_core.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap_core
// Separating axis overlap test of a triangle against an axis-aligned box.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  s_axis   in         center xyz, vertex 0..2 xyz, 24 bits each
//  m_axis   out        overlaps flag
//  cfg      in         half size x, y, z of the box
//
// One item enters per cycle while s_axis_tready is high and passes through
// eight register stages; its result is offered from the last of them.
// Each stage only holds when the stage after it is full and held, so empty
// stages close up under a stall and nothing is lost or repeated.
// Reset empties the pipeline and loads 2048 into the three half sizes.
// Half sizes must only be written while the pipeline is empty.
//
// Stage 1: vertices relative to the box center.
// Stage 2: triangle edges and the min/max extent test.
// Stage 3: all edge products of the nine cross axes and of the normal.
// Stage 4: projections, projected box radii and the normal.
// Stage 5: edge-axis decision and the split products of the plane test.
// Stage 6: per-axis distance and reach of the plane test.
// Stage 7: sums over the axes.
// Stage 8: final plane compare, result register.
`include "assert_macros.svh"

module triangle_box_overlap_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x, center_y, center_z, vert0_x .. vert2_z, 24 bits each, from bit 0
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // overlaps in bit 0, upper bits zero
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [22:0]  cfg_data_i
);

  localparam int NS = tbo_pkg::NumStages;

  // Configuration registers.
  tbo_pkg::half_t half_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= tbo_pkg::HalfReset;
      half_q[1] <= tbo_pkg::HalfReset;
      half_q[2] <= tbo_pkg::HalfReset;
    end else if (cfg_valid_i) begin
      unique case (tbo_pkg::reg_idx_e'(cfg_index_i))
        tbo_pkg::REG_HALF_X: half_q[0] <= cfg_data_i;
        tbo_pkg::REG_HALF_Y: half_q[1] <= cfg_data_i;
        tbo_pkg::REG_HALF_Z: half_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or its content moves on.
  logic [NS:1]   vld_q;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = m_axis_tready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[1];

  // Stage 1: relative vertices.
  tbo_pkg::rel_t v1_d [3][3];
  tbo_pkg::rel_t v1_q [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int q = 0; q < 3; q++) begin
        v1_d[a][q] =
          tbo_pkg::rel_t'(signed'(s_axis_tdata[(3+3*a+q)*24 +: 24]))
          - tbo_pkg::rel_t'(signed'(s_axis_tdata[q*24 +: 24]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) v1_q <= v1_d;
  end

  // Stage 2: edges and the extent test.
  tbo_pkg::edge_t e2_d [3][3];
  tbo_pkg::edge_t e2_q [3][3];
  tbo_pkg::rel_t  v2_q [3][3];
  logic           ext2_d, ext2_q;

  always_comb begin
    tbo_pkg::rel_t lo, hi;
    logic signed [25:0] h;
    ext2_d = 1'b0;
    for (int q = 0; q < 3; q++) begin
      e2_d[0][q] = tbo_pkg::edge_t'(v1_q[1][q]) - tbo_pkg::edge_t'(v1_q[0][q]);
      e2_d[1][q] = tbo_pkg::edge_t'(v1_q[2][q]) - tbo_pkg::edge_t'(v1_q[1][q]);
      e2_d[2][q] = tbo_pkg::edge_t'(v1_q[0][q]) - tbo_pkg::edge_t'(v1_q[2][q]);
      lo = v1_q[0][q];
      hi = v1_q[0][q];
      for (int a = 1; a < 3; a++) begin
        if (v1_q[a][q] < lo) lo = v1_q[a][q];
        if (v1_q[a][q] > hi) hi = v1_q[a][q];
      end
      h = $signed({3'b000, half_q[q]});
      if (26'(lo) > h || 26'(hi) < -h) ext2_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      e2_q   <= e2_d;
      v2_q   <= v1_q;
      ext2_q <= ext2_d;
    end
  end

  // Stage 3: products. Axis m = 3 * edge + coordinate axis.
  tbo_pkg::prod_t  pa3_d [9][3], pa3_q [9][3];
  tbo_pkg::prod_t  pb3_d [9][3], pb3_q [9][3];
  tbo_pkg::radp_t  ra3_d [9], ra3_q [9];
  tbo_pkg::radp_t  rb3_d [9], rb3_q [9];
  tbo_pkg::nprod_t na3_d [3], na3_q [3];
  tbo_pkg::nprod_t nb3_d [3], nb3_q [3];
  tbo_pkg::rel_t   v03_q [3];
  logic            ext3_q;

  always_comb begin
    logic [25:0] mi, mj;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        mi = (e2_q[a][tbo_pkg::Next1[k]] < 0) ? 26'(-e2_q[a][tbo_pkg::Next1[k]])
                                              : 26'(e2_q[a][tbo_pkg::Next1[k]]);
        mj = (e2_q[a][tbo_pkg::Next2[k]] < 0) ? 26'(-e2_q[a][tbo_pkg::Next2[k]])
                                              : 26'(e2_q[a][tbo_pkg::Next2[k]]);
        ra3_d[3*a+k] = 49'(mj) * 49'(half_q[tbo_pkg::Next1[k]]);
        rb3_d[3*a+k] = 49'(mi) * 49'(half_q[tbo_pkg::Next2[k]]);
        for (int t = 0; t < 3; t++) begin
          pa3_d[3*a+k][t] = e2_q[a][tbo_pkg::Next2[k]] * v2_q[t][tbo_pkg::Next1[k]];
          pb3_d[3*a+k][t] = e2_q[a][tbo_pkg::Next1[k]] * v2_q[t][tbo_pkg::Next2[k]];
        end
      end
    end
    for (int q = 0; q < 3; q++) begin
      na3_d[q] = e2_q[0][tbo_pkg::Next1[q]] * e2_q[1][tbo_pkg::Next2[q]];
      nb3_d[q] = e2_q[0][tbo_pkg::Next2[q]] * e2_q[1][tbo_pkg::Next1[q]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pa3_q  <= pa3_d;
      pb3_q  <= pb3_d;
      ra3_q  <= ra3_d;
      rb3_q  <= rb3_d;
      na3_q  <= na3_d;
      nb3_q  <= nb3_d;
      v03_q  <= v2_q[0];
      ext3_q <= ext2_q;
    end
  end

  // Stage 4: projections, radii and the triangle normal.
  tbo_pkg::proj_t p4_d [9][3], p4_q [9][3];
  tbo_pkg::rad_t  r4_d [9], r4_q [9];
  tbo_pkg::norm_t n4_d [3], n4_q [3];
  tbo_pkg::rel_t  v04_q [3];
  logic           ext4_q;

  always_comb begin
    for (int m = 0; m < 9; m++) begin
      r4_d[m] = 50'(ra3_q[m]) + 50'(rb3_q[m]);
      for (int t = 0; t < 3; t++) begin
        p4_d[m][t] = tbo_pkg::proj_t'(pa3_q[m][t]) - tbo_pkg::proj_t'(pb3_q[m][t]);
      end
    end
    for (int q = 0; q < 3; q++) begin
      n4_d[q] = tbo_pkg::norm_t'(na3_q[q]) - tbo_pkg::norm_t'(nb3_q[q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p4_q   <= p4_d;
      r4_q   <= r4_d;
      n4_q   <= n4_d;
      v04_q  <= v03_q;
      ext4_q <= ext3_q;
    end
  end

  // Stage 5: edge-axis decision; the 53-bit normal is split at bit 27 so
  // that each plane product stays below 32 by 32 bits.
  tbo_pkg::plo_t pl5_d [3], pl5_q [3];
  tbo_pkg::phi_t ph5_d [3], ph5_q [3];
  tbo_pkg::rlo_t rl5_d [3], rl5_q [3];
  tbo_pkg::rhi_t rh5_d [3], rh5_q [3];
  logic          sep5_d, sep5_q;

  always_comb begin
    tbo_pkg::proj_t     lo, hi;
    logic signed [53:0] rs;
    logic [52:0]        nm;
    sep5_d = ext4_q;
    for (int m = 0; m < 9; m++) begin
      lo = p4_q[m][0];
      hi = p4_q[m][0];
      for (int t = 1; t < 3; t++) begin
        if (p4_q[m][t] < lo) lo = p4_q[m][t];
        if (p4_q[m][t] > hi) hi = p4_q[m][t];
      end
      rs = $signed({4'b0000, r4_q[m]});
      if (rs < 54'(lo) || 54'(hi) < -rs) sep5_d = 1'b1;
    end
    for (int q = 0; q < 3; q++) begin
      nm = (n4_q[q] < 0) ? 53'(-n4_q[q]) : 53'(n4_q[q]);
      pl5_d[q] = $signed({1'b0, n4_q[q][26:0]}) * v04_q[q];
      ph5_d[q] = $signed(n4_q[q][52:27]) * v04_q[q];
      rl5_d[q] = 50'(nm[26:0]) * 50'(half_q[q]);
      rh5_d[q] = 49'(nm[52:27]) * 49'(half_q[q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      pl5_q  <= pl5_d;
      ph5_q  <= ph5_d;
      rl5_q  <= rl5_d;
      rh5_q  <= rh5_d;
      sep5_q <= sep5_d;
    end
  end

  // Stage 6: per-axis distance and reach.
  tbo_pkg::wide_t d6_d [3], d6_q [3];
  tbo_pkg::wide_t r6_d [3], r6_q [3];
  logic           sep6_q;

  always_comb begin
    for (int q = 0; q < 3; q++) begin
      d6_d[q] = (tbo_pkg::wide_t'(ph5_q[q]) <<< 27) + tbo_pkg::wide_t'(pl5_q[q]);
      r6_d[q] = $signed((80'(rh5_q[q]) << 27) + 80'(rl5_q[q]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      d6_q   <= d6_d;
      r6_q   <= r6_d;
      sep6_q <= sep5_q;
    end
  end

  // Stage 7: sums over the three axes.
  tbo_pkg::wide_t dist7_q, reach7_q;
  logic           sep7_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      dist7_q  <= d6_q[0] + d6_q[1] + d6_q[2];
      reach7_q <= r6_q[0] + r6_q[1] + r6_q[2];
      sep7_q   <= sep6_q;
    end
  end

  // Stage 8: plane test and result register.
  logic ovl_d, ovl_q;

  assign ovl_d = !sep7_q && !(dist7_q < -reach7_q || reach7_q < dist7_q);

  always_ff @(posedge clk_i) begin
    if (en[8]) ovl_q <= ovl_d;
  end

  assign m_axis_tvalid = vld_q[NS];
  assign m_axis_tdata  = {7'b0, ovl_q};

  `ASSERT_CLK(a_ready_only_when_full, !s_axis_tready |-> (&vld_q), "input stalled with a bubble")
  `ASSERT_CLK(a_cfg_write_x,
    cfg_valid_i && cfg_index_i == tbo_pkg::REG_HALF_X |=> half_q[0] == $past(cfg_data_i),
    "half size x not written")
  `ASSERT_CLK(a_sep_gives_miss, vld_q[7] && sep7_q && en[8] |=> !ovl_q,
    "separated item reported as overlapping")

endmodule
